[sv/e2c_pkg.sv]
// ----------------------------------------------------------------------------
// e2c_pkg: shared types, constants and arithmetic helpers
// Constants and digit-step functions for the epoch to calendar pipeline.
// ----------------------------------------------------------------------------
package e2c_pkg;

  // Seconds divider: magnitude >> 7, then radix-256 long division by 675
  localparam int SD_DIGITS = 7;
  localparam logic [9:0]  SD_DIV   = 10'd675;
  localparam logic [14:0] SD_RECIP = 15'd24855;     // floor(2^24 / 675)

  // Era divider: one prep stage, then three radix-256 digits by 146097
  localparam int ED_STAGES = 4;
  localparam logic [17:0] ERA_DAYS  = 18'd146097;
  localparam logic [17:0] ERA_LAST  = 18'd146096;
  localparam logic [14:0] ERA_RECIP = 15'd29398;    // floor(2^32 / 146097)

  localparam logic [16:0] SOD_LAST    = 17'd86399;
  localparam logic [41:0] EPOCH_SHIFT = 42'd719468;
  localparam logic [35:0] YEAR_BASE   = 36'd1900;

  // Calendar stages and reciprocals for the constant divisions
  localparam int CV_STAGES = 6;
  localparam logic [15:0] HOUR_RECIP  = 16'd37283;   // ceil(2^27 / 3600)
  localparam logic [12:0] MIN_RECIP   = 13'd4370;    // ceil(2^18 / 60)
  localparam logic [17:0] Q1460_RECIP = 18'd183860;  // ceil(2^28 / 1460)
  localparam logic [17:0] YEAR_RECIP  = 18'd183860;  // ceil(2^26 / 365)
  localparam logic [17:0] WEEK_RECIP  = 18'd149797;  // ceil(2^20 / 7)
  localparam logic [12:0] MP_RECIP    = 13'd6854;    // ceil(2^20 / 153)

  typedef struct packed {
    logic        neg;
    logic [62:0] n;
    logic [55:0] q;
    logic [9:0]  rem;
  } sd_stage_t;

  typedef struct packed {
    logic        ok;
    logic        zneg;
    logic [40:0] n;
    logic [23:0] q;
    logic [17:0] rem;
    logic [16:0] sod;
  } ed_stage_t;

  typedef struct packed {
    logic        valid_res;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day_of_month;
    logic [3:0]  month;
    logic [31:0] years_since_1900;
    logic [2:0]  weekday;
    logic [8:0]  year_day;
  } cal_t;

  // One long-division digit by 675: returns {quotient digit, remainder}
  function automatic logic [17:0] div675_step(input logic [9:0] rem, input logic [7:0] dig);
    logic [17:0] v;
    logic [32:0] p;
    logic [7:0]  q;
    logic [17:0] r;
    v = {rem, dig};
    p = 33'(v) * 33'(SD_RECIP);
    q = p[31:24];
    r = v - 18'(q) * 18'(SD_DIV);
    if (r >= 18'(SD_DIV)) begin
      q = q + 8'd1;
      r = r - 18'(SD_DIV);
    end
    return {q, r[9:0]};
  endfunction

  // One long-division digit by 146097: returns {quotient digit, remainder}
  function automatic logic [25:0] div_era_step(input logic [17:0] rem, input logic [7:0] dig);
    logic [25:0] v;
    logic [40:0] p;
    logic [7:0]  q;
    logic [25:0] r;
    v = {rem, dig};
    p = 41'(v) * 41'(ERA_RECIP);
    q = p[39:32];
    r = v - 26'(q) * 26'(ERA_DAYS);
    if (r >= 26'(ERA_DAYS)) begin
      q = q + 8'd1;
      r = r - 26'(ERA_DAYS);
    end
    return {q, r[17:0]};
  endfunction

  // Day offset of each March-based month from March 1
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

[sv/e2c_sec_div.sv]
// ----------------------------------------------------------------------------
// e2c_sec_div: seconds to day number divider
// Pipelined floor division of the signed seconds by 86400, one byte a stage.
// ----------------------------------------------------------------------------
module e2c_sec_div (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  up_valid,
  output logic                  up_stall,
  input  logic [63:0]           up_secs,
  output logic                  dn_valid,
  input  logic                  dn_stall,
  output e2c_pkg::sd_stage_t    dn_data
);
  localparam int N = e2c_pkg::SD_DIGITS;

  e2c_pkg::sd_stage_t st [N];
  e2c_pkg::sd_stage_t src [N];
  e2c_pkg::sd_stage_t nxt [N];
  logic vld [N];
  logic src_v [N];
  logic adv [N];

  // Negative inputs divide their complement; the result is complemented later
  always_comb begin
    src[0].neg = up_secs[63];
    src[0].n   = up_secs[63] ? ~up_secs[62:0] : up_secs[62:0];
    src[0].q   = '0;
    src[0].rem = '0;
    src_v[0]   = up_valid;
    for (int k = 1; k < N; k++) begin
      src[k]   = st[k-1];
      src_v[k] = vld[k-1];
    end
  end

  assign adv[N-1] = !vld[N-1] || !dn_stall;

  generate
    for (genvar k = 0; k < N - 1; k++) begin : g_adv
      assign adv[k] = !vld[k] || adv[k+1];
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
      always_comb begin
        logic [17:0] qr;
        qr = e2c_pkg::div675_step(src[k].rem, src[k].n[62-8*k -: 8]);
        nxt[k] = src[k];
        nxt[k].q[55-8*k -: 8] = qr[17:10];
        nxt[k].rem = qr[9:0];
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (adv[k]) begin
          vld[k] <= src_v[k];
        end
      end

      always_ff @(posedge clk) begin
        if (adv[k]) begin
          st[k] <= nxt[k];
        end
      end
    end
  endgenerate

  assign up_stall = !adv[0];
  assign dn_valid = vld[N-1];
  assign dn_data  = st[N-1];
endmodule

[sv/e2c_era_div.sv]
// ----------------------------------------------------------------------------
// e2c_era_div: day number to era divider
// Fixes sign of the day count, range-checks it and divides by 146097 days.
// ----------------------------------------------------------------------------
module e2c_era_div (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  up_valid,
  output logic                  up_stall,
  input  e2c_pkg::sd_stage_t    up_data,
  output logic                  dn_valid,
  input  logic                  dn_stall,
  output e2c_pkg::ed_stage_t    dn_data
);
  localparam int N = e2c_pkg::ED_STAGES;

  e2c_pkg::ed_stage_t st [N];
  e2c_pkg::ed_stage_t nxt [N];
  logic vld [N];
  logic adv [N];

  // Prep: signed days, second of day, range flag, shifted day count
  always_comb begin
    logic [56:0] days;
    logic [16:0] sodp;
    logic [41:0] z;
    days = up_data.neg ? ~{1'b0, up_data.q} : {1'b0, up_data.q};
    sodp = {up_data.rem, up_data.n[6:0]};
    z    = {days[40], days[40:0]} + e2c_pkg::EPOCH_SHIFT;
    nxt[0].ok   = (days[56:40] == {17{days[56]}});
    nxt[0].sod  = up_data.neg ? e2c_pkg::SOD_LAST - sodp : sodp;
    nxt[0].zneg = z[41];
    nxt[0].n    = z[41] ? ~z[40:0] : z[40:0];
    nxt[0].q    = '0;
    nxt[0].rem  = {1'b0, nxt[0].n[40:24]};
  end

  assign adv[N-1] = !vld[N-1] || !dn_stall;

  generate
    for (genvar k = 0; k < N - 1; k++) begin : g_adv
      assign adv[k] = !vld[k] || adv[k+1];
    end

    for (genvar k = 1; k < N; k++) begin : g_digit
      always_comb begin
        logic [25:0] qr;
        qr = e2c_pkg::div_era_step(st[k-1].rem, st[k-1].n[31-8*k -: 8]);
        nxt[k] = st[k-1];
        nxt[k].q[31-8*k -: 8] = qr[25:18];
        nxt[k].rem = qr[17:0];
      end
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (adv[k]) begin
          vld[k] <= (k == 0) ? up_valid : vld[(k == 0) ? 0 : k - 1];
        end
      end

      always_ff @(posedge clk) begin
        if (adv[k]) begin
          st[k] <= nxt[k];
        end
      end
    end
  endgenerate

  assign up_stall = !adv[0];
  assign dn_valid = vld[N-1];
  assign dn_data  = st[N-1];
endmodule

[sv/e2c_civil.sv]
// ----------------------------------------------------------------------------
// e2c_civil: era and day of era to calendar fields
// Six stages: year of era, day of year, month, day, weekday and time of day.
// ----------------------------------------------------------------------------
module e2c_civil (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  up_valid,
  output logic                  up_stall,
  input  e2c_pkg::ed_stage_t    up_data,
  output logic                  dn_valid,
  input  logic                  dn_stall,
  output e2c_pkg::cal_t         dn_data
);
  localparam int N = e2c_pkg::CV_STAGES;

  typedef struct packed {
    logic ok; logic [24:0] era; logic [17:0] doe; logic [16:0] sod; logic [4:0] hour;
  } c1_t;
  typedef struct packed {
    logic ok; logic [24:0] era; logic [17:0] doe; logic [4:0] hour;
    logic [11:0] hrem; logic [17:0] t; logic [2:0] wd;
  } c2_t;
  typedef struct packed {
    logic ok; logic [24:0] era; logic [17:0] doe; logic [4:0] hour;
    logic [11:0] hrem; logic [2:0] wd; logic [8:0] yoe; logic [5:0] minute;
  } c3_t;
  typedef struct packed {
    logic ok; logic [34:0] y0; logic [8:0] doy; logic leap; logic [4:0] hour;
    logic [5:0] minute; logic [5:0] second; logic [2:0] wd;
  } c4_t;
  typedef struct packed {
    logic ok; logic [34:0] y0; logic [8:0] doy; logic leap; logic [4:0] hour;
    logic [5:0] minute; logic [5:0] second; logic [2:0] wd; logic [3:0] mp;
  } c5_t;

  c1_t c1, c1_next;
  c2_t c2, c2_next;
  c3_t c3, c3_next;
  c4_t c4, c4_next;
  c5_t c5, c5_next;
  e2c_pkg::cal_t c6, c6_next;
  logic vld [N];
  logic adv [N];

  // Era and day of era from the divider, hour of day
  always_comb begin
    logic [33:0] ph;
    ph = 34'(up_data.sod) * 34'(e2c_pkg::HOUR_RECIP);
    c1_next.ok   = up_data.ok;
    c1_next.era  = up_data.zneg ? ~{1'b0, up_data.q} : {1'b0, up_data.q};
    c1_next.doe  = up_data.zneg ? e2c_pkg::ERA_LAST - up_data.rem : up_data.rem;
    c1_next.sod  = up_data.sod;
    c1_next.hour = ph[31:27];
  end

  // Leap-corrected day of era, weekday, seconds left in the hour
  always_comb begin
    logic [35:0] pa;
    logic [6:0]  a;
    logic [2:0]  b;
    logic        c;
    logic [17:0] x;
    logic [35:0] pw;
    logic [14:0] qw;
    logic [17:0] rw;
    pa = 36'(c1.doe) * 36'(e2c_pkg::Q1460_RECIP);
    a  = pa[34:28];
    b  = 3'(c1.doe >= 18'd36524) + 3'(c1.doe >= 18'd73048) +
         3'(c1.doe >= 18'd109572) + 3'(c1.doe >= e2c_pkg::ERA_LAST);
    c  = (c1.doe == e2c_pkg::ERA_LAST);
    x  = c1.doe + 18'd3;
    pw = 36'(x) * 36'(e2c_pkg::WEEK_RECIP);
    qw = pw[34:20];
    rw = x - ({qw, 3'b000} - {3'b000, qw});
    c2_next.ok   = c1.ok;
    c2_next.era  = c1.era;
    c2_next.doe  = c1.doe;
    c2_next.hour = c1.hour;
    c2_next.hrem = 12'(c1.sod - 17'(c1.hour) * 17'd3600);
    c2_next.t    = c1.doe - 18'(a) + 18'(b) - 18'(c);
    c2_next.wd   = rw[2:0];
  end

  // Year of era, minute
  always_comb begin
    logic [35:0] py;
    logic [24:0] pm;
    py = 36'(c2.t) * 36'(e2c_pkg::YEAR_RECIP);
    pm = 25'(c2.hrem) * 25'(e2c_pkg::MIN_RECIP);
    c3_next.ok     = c2.ok;
    c3_next.era    = c2.era;
    c3_next.doe    = c2.doe;
    c3_next.hour   = c2.hour;
    c3_next.hrem   = c2.hrem;
    c3_next.wd     = c2.wd;
    c3_next.yoe    = py[34:26];
    c3_next.minute = pm[23:18];
  end

  // Day of March-based year, leap flag, base year, second
  always_comb begin
    logic [1:0]  cent;
    logic [17:0] base;
    logic        hund;
    hund = (c3.yoe == 9'd100) || (c3.yoe == 9'd200) || (c3.yoe == 9'd300);
    cent = 2'(c3.yoe >= 9'd100) + 2'(c3.yoe >= 9'd200) + 2'(c3.yoe >= 9'd300);
    base = 18'(c3.yoe) * 18'd365 + 18'(c3.yoe[8:2]) - 18'(cent);
    c4_next.ok     = c3.ok;
    c4_next.y0     = {{10{c3.era[24]}}, c3.era} * 35'd400 + 35'(c3.yoe);
    c4_next.doy    = 9'(c3.doe - base);
    c4_next.leap   = (c3.yoe[1:0] == 2'b00) && !hund;
    c4_next.hour   = c3.hour;
    c4_next.minute = c3.minute;
    c4_next.second = 6'(c3.hrem - 12'(c3.minute) * 12'd60);
    c4_next.wd     = c3.wd;
  end

  // March-based month
  always_comb begin
    logic [10:0] v;
    logic [23:0] pmp;
    v   = 11'(c4.doy) * 11'd5 + 11'd2;
    pmp = 24'(v) * 24'(e2c_pkg::MP_RECIP);
    c5_next.ok     = c4.ok;
    c5_next.y0     = c4.y0;
    c5_next.doy    = c4.doy;
    c5_next.leap   = c4.leap;
    c5_next.hour   = c4.hour;
    c5_next.minute = c4.minute;
    c5_next.second = c4.second;
    c5_next.wd     = c4.wd;
    c5_next.mp     = pmp[23:20];
  end

  // Final fields; bad day range or year offset outside 32 bits zeroes the result
  always_comb begin
    logic        late;
    logic [35:0] yoff;
    logic        ok;
    late = (c5.mp >= 4'd10);
    yoff = {c5.y0[34], c5.y0} + 36'(late) - e2c_pkg::YEAR_BASE;
    ok   = c5.ok && (yoff[35:31] == {5{yoff[35]}});
    c6_next = '0;
    if (ok) begin
      c6_next.valid_res        = 1'b1;
      c6_next.second           = c5.second;
      c6_next.minute           = c5.minute;
      c6_next.hour             = c5.hour;
      c6_next.day_of_month     = 5'(c5.doy - e2c_pkg::month_start(c5.mp) + 9'd1);
      c6_next.month            = late ? c5.mp - 4'd10 : c5.mp + 4'd2;
      c6_next.years_since_1900 = yoff[31:0];
      c6_next.weekday          = c5.wd;
      c6_next.year_day         = late ? c5.doy - 9'd306 : c5.doy + 9'd59 + 9'(c5.leap);
    end
  end

  assign adv[N-1] = !vld[N-1] || !dn_stall;

  generate
    for (genvar k = 0; k < N - 1; k++) begin : g_adv
      assign adv[k] = !vld[k] || adv[k+1];
    end
    for (genvar k = 0; k < N; k++) begin : g_vld
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (adv[k]) begin
          vld[k] <= (k == 0) ? up_valid : vld[(k == 0) ? 0 : k - 1];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (adv[0]) c1 <= c1_next;
    if (adv[1]) c2 <= c2_next;
    if (adv[2]) c3 <= c3_next;
    if (adv[3]) c4 <= c4_next;
    if (adv[4]) c5 <= c5_next;
    if (adv[5]) c6 <= c6_next;
  end

  assign up_stall = !adv[0];
  assign dn_valid = vld[N-1];
  assign dn_data  = c6;
endmodule

[sv/epoch_seconds_to_calendar.sv]
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar: signed epoch seconds to UTC calendar fields
// Floor-divides seconds into days, splits days into 400-year eras and
// derives year, month, day, weekday, day of year and time of day.
// ----------------------------------------------------------------------------
// Pipeline: 7 seconds-divider stages, 4 era-divider stages, 6 calendar stages.
// Throughput: one beat per cycle while out_stall is low; the per-byte divider
//   stages set the depth. Each stage holds its beat only while the one after
//   it is full and stalled, so bubbles close up and the input side keeps
//   accepting.
// Reset (rst, synchronous): clears all stage valid bits; data is not reset.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [63:0] epoch_seconds,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               valid_res,
  output logic [5:0]         second,
  output logic [5:0]         minute,
  output logic [4:0]         hour,
  output logic [4:0]         day_of_month,
  output logic [3:0]         month,
  output logic signed [31:0] years_since_1900,
  output logic [2:0]         weekday,
  output logic [8:0]         year_day
);
  e2c_pkg::sd_stage_t sd_data;
  e2c_pkg::ed_stage_t ed_data;
  e2c_pkg::cal_t      cal;
  logic sd_valid, sd_stall;
  logic ed_valid, ed_stall;

  // Seconds to days: sign-fold, then one byte of quotient per stage
  e2c_sec_div u_sec_div (
    .clk      (clk),
    .rst      (rst),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .up_secs  (epoch_seconds),
    .dn_valid (sd_valid),
    .dn_stall (sd_stall),
    .dn_data  (sd_data)
  );

  // Days to era and day of era, with the coarse day-range check
  e2c_era_div u_era_div (
    .clk      (clk),
    .rst      (rst),
    .up_valid (sd_valid),
    .up_stall (sd_stall),
    .up_data  (sd_data),
    .dn_valid (ed_valid),
    .dn_stall (ed_stall),
    .dn_data  (ed_data)
  );

  // Calendar fields; its last stage is the output register
  e2c_civil u_civil (
    .clk      (clk),
    .rst      (rst),
    .up_valid (ed_valid),
    .up_stall (ed_stall),
    .up_data  (ed_data),
    .dn_valid (out_valid),
    .dn_stall (out_stall),
    .dn_data  (cal)
  );

  assign valid_res        = cal.valid_res;
  assign second           = cal.second;
  assign minute           = cal.minute;
  assign hour             = cal.hour;
  assign day_of_month     = cal.day_of_month;
  assign month            = cal.month;
  assign years_since_1900 = cal.years_since_1900;
  assign weekday          = cal.weekday;
  assign year_day         = cal.year_day;

  // A range error drives every field to zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> second == 6'd0 && minute == 6'd0 && hour == 5'd0 &&
      day_of_month == 5'd0 && month == 4'd0 && years_since_1900 == 32'sd0 &&
      weekday == 3'd0 && year_day == 9'd0)
    else $error("range error result carries nonzero fields");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && valid_res |-> second <= 6'd59 && minute <= 6'd59 && hour <= 5'd23)
    else $error("time of day out of range");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && valid_res |-> day_of_month >= 5'd1 && month <= 4'd11)
    else $error("month or day out of range");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && valid_res |-> weekday <= 3'd6 && year_day <= 9'd365)
    else $error("weekday or day of year out of range");
endmodule

[tb/epoch_seconds_to_calendar_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_tb: self-checking bench for the epoch converter
// Drives signed epoch seconds, predicts the UTC calendar fields of each beat
// and checks every result beat in order under random and long back-pressure.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PIPE_DEPTH  = 17;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic signed [63:0] epoch_seconds;
  logic               out_valid;
  logic               out_stall;
  logic               valid_res;
  logic [5:0]         second;
  logic [5:0]         minute;
  logic [4:0]         hour;
  logic [4:0]         day_of_month;
  logic [3:0]         month;
  logic signed [31:0] years_since_1900;
  logic [2:0]         weekday;
  logic [8:0]         year_day;

  // Calendar fields still owed by the block, oldest first
  e2c_pkg::cal_t pending_dates[$];
  int   mismatch_count;
  int   cycle_count;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   recv_hold_cycles;

  epoch_seconds_to_calendar u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .epoch_seconds(epoch_seconds),
    .out_valid(out_valid), .out_stall(out_stall),
    .valid_res(valid_res), .second(second), .minute(minute), .hour(hour),
    .day_of_month(day_of_month), .month(month),
    .years_since_1900(years_since_1900), .weekday(weekday), .year_day(year_day)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Bound the run; a hung handshake ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------
  // Floor division: round toward minus infinity so negative times land on the
  // earlier day / era.
  function automatic longint floor_quot(longint v, longint d);
    longint q;
    q = v / d;
    if (v % d < 0) q = q - 1;
    return q;
  endfunction

  // Day number (days since 1970-01-01) of January 1 of the given year
  function automatic longint jan1_day_number(longint year);
    longint yy, era, yoe, doe;
    yy  = year - 1;
    era = floor_quot(yy, 400);
    yoe = yy - era * 400;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + 306;
    return era * 146097 + doe - 719468;
  endfunction

  function automatic e2c_pkg::cal_t civil_from_epoch(longint secs);
    e2c_pkg::cal_t c;
    longint days, sod, z, era, doe, yoe, y, doy, mp, d, m, yoff, wd;
    days = floor_quot(secs, 86400);
    sod  = secs - days * 86400;
    z    = days + 719468;
    era  = floor_quot(z, 146097);
    doe  = z - era * 146097;
    yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    y    = yoe + era * 400;
    doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp   = (5 * doy + 2) / 153;
    d    = doy - (153 * mp + 2) / 5 + 1;
    m    = (mp < 10) ? mp + 3 : mp - 9;
    if (m <= 2) y = y + 1;
    yoff = y - 1900;
    c = '0;
    // Out-of-range year: flag low, every field zero
    if (yoff < -64'sd2147483648 || yoff > 64'sd2147483647) return c;
    wd = (days + 4) % 7;
    if (wd < 0) wd = wd + 7;
    c.valid_res        = 1'b1;
    c.second           = 6'(sod % 60);
    c.minute           = 6'((sod / 60) % 60);
    c.hour             = 5'(sod / 3600);
    c.day_of_month     = 5'(d);
    c.month            = 4'(m - 1);
    c.years_since_1900 = 32'(yoff);
    c.weekday          = 3'(wd);
    c.year_day         = 9'(days - jan1_day_number(y));
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one beat, held until the block takes it
  // ---------------------------------------------------------------------------
  task automatic send_epoch(longint secs);
    int gap;
    bit taken;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    epoch_seconds <= secs;
    // in_stall is settled by the falling edge; the next rising edge accepts
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    pending_dates.push_back(civil_from_epoch(secs));
  endtask

  // Drop valid and move to the next edge before anything else is driven
  task automatic release_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall, or a long hold when a test asks for one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (recv_hold_cycles > 0) begin
      out_stall <= 1'b1;
      recv_hold_cycles = recv_hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", field, got, want, cycle_count);
    mismatch_count++;
  endtask

  // Check each result beat against the oldest prediction
  always @(negedge clk) begin
    e2c_pkg::cal_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_dates.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        want = pending_dates.pop_front();
        if (valid_res !== want.valid_res)
          report_mismatch("valid_res", valid_res, want.valid_res);
        if (second !== want.second) report_mismatch("second", second, want.second);
        if (minute !== want.minute) report_mismatch("minute", minute, want.minute);
        if (hour !== want.hour) report_mismatch("hour", hour, want.hour);
        if (day_of_month !== want.day_of_month)
          report_mismatch("day_of_month", day_of_month, want.day_of_month);
        if (month !== want.month)
          report_mismatch("month", month, want.month);
        if (years_since_1900 !== want.years_since_1900)
          report_mismatch("years_since_1900", years_since_1900,
                          $signed(want.years_since_1900));
        if (weekday !== want.weekday) report_mismatch("weekday", weekday, want.weekday);
        if (year_day !== want.year_day)
          report_mismatch("year_day", year_day, want.year_day);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Extremes, day and leap boundaries, and the edges of the valid year range
  task automatic test_directed();
    longint cases[$];
    cases = '{64'sd0, -64'sd1, 64'sd1, 64'sd86399, 64'sd86400, -64'sd86400,
              -64'sd86401, 64'sd951782400, 64'sd951868800, 64'sd4107542400,
              64'sd4107456000, 64'sd978307199, 64'sd253402300799,
              -64'sd62135596800, -64'sd62135596801, -64'sd11644473600,
              64'sd67768036191676799, 64'sd67768036191676800,
              -64'sd67768040609740800, -64'sd67768040609740801,
              64'h7FFF_FFFF_FFFF_FFFF, 64'sh8000_0000_0000_0000,
              64'sd1709251199, 64'sd13569465599};
    foreach (cases[i]) send_epoch(cases[i]);
    release_input();
  endtask

  // Mixed random times: mostly in-range, some full 64-bit noise, some near edges
  function automatic longint random_epoch();
    longint v;
    int pick;
    pick = $urandom_range(99);
    v = {$urandom(), $urandom()};
    if (pick < 25) return v;
    if (pick < 60) return v >>> 24;                      // about +/- 17000 years
    if (pick < 80) return (v >>> 30) * 86400 + longint'($urandom_range(2)) - 1;  // midnights
    if (pick < 90) return 64'sd67768036191676799 - (v & 64'hFFFF_FFFF) + 64'sd2147483648;
    return -64'sd67768040609740800 + (v & 64'hFFFF_FFFF) - 64'sd2147483648;
  endfunction

  task automatic test_random(int count, int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_epoch(random_epoch());
    release_input();
  endtask

  // Hold the output for a long stretch while beats keep coming, so the
  // pipeline fills and stalls its input
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    recv_hold_cycles = 120;
    repeat (60) send_epoch(random_epoch());
    release_input();
  endtask

  // Pause the sender until every result is back, then send a burst
  task automatic test_drain_pause();
    wait (pending_dates.size() == 0);
    @(posedge clk);
    repeat (20) send_epoch(random_epoch());
    release_input();
  endtask

  initial begin
    rst              = 1'b1;
    in_valid         = 1'b0;
    epoch_seconds    = '0;
    out_stall        = 1'b0;
    mismatch_count   = 0;
    cycle_count      = 0;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    recv_hold_cycles = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(180, 15, 71);
    test_random(180, 71, 15);
    test_random(130, 0, 0);
    test_backpressure();
    test_drain_pause();

    // Drain, then let the pipeline settle before the verdict
    wait (pending_dates.size() == 0);
    repeat (PIPE_DEPTH + 20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
sv/e2c_pkg.sv
sv/e2c_sec_div.sv
sv/e2c_era_div.sv
sv/e2c_civil.sv
sv/epoch_seconds_to_calendar.sv
tb/epoch_seconds_to_calendar_tb.sv
